@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RC2 block RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/rc2_pkg.sv @@
// Types, codes and the pi permutation for the RC2 block.
// No dependencies; used by rc2_round, rc2_expand and rc2_block_cipher.
`timescale 1ns / 1ps
`default_nettype none
package rc2_pkg;
   typedef logic [15:0] word_type;

   typedef enum logic [1:0] {
      REQ_KEY  = 2'd0,
      REQ_ENC  = 2'd1,
      REQ_DEC  = 2'd2,
      REQ_NONE = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      EX_IDLE, EX_START, EX_STR_RD, EX_STR_WR, EX_CUT_RD, EX_CUT_WR,
      EX_FOLD_RD, EX_FOLD_WR, EX_COPY_RD, EX_COPY_WR
   } exp_state_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_ADDR, BK_EXEC, BK_DONE
   } blk_state_type;

   typedef struct packed {
      logic       dec;
      logic       mash;
      logic [1:0] idx;
   } round_ctl_type;

   localparam logic [7:0]  KEY_BYTES    = 8'd128;
   localparam logic [7:0]  KEY_LAST_IDX = 8'd127;
   localparam logic [10:0] EFF_BITS_MAX = 11'd1024;
   localparam logic [5:0]  KEY_WORD_TOP = 6'd63;
   localparam logic [3:0]  ROUND_LAST   = 4'd15;
   localparam logic [3:0]  MASH_RND_A   = 4'd4;
   localparam logic [3:0]  MASH_RND_B   = 4'd10;

   localparam logic [7:0] PI_TABLE [256] = '{
      8'hD9,8'h78,8'hF9,8'hC4,8'h19,8'hDD,8'hB5,8'hED,8'h28,8'hE9,8'hFD,8'h79,8'h4A,8'hA0,
      8'hD8,8'h9D,8'hC6,8'h7E,8'h37,8'h83,8'h2B,8'h76,8'h53,8'h8E,8'h62,8'h4C,8'h64,8'h88,
      8'h44,8'h8B,8'hFB,8'hA2,8'h17,8'h9A,8'h59,8'hF5,8'h87,8'hB3,8'h4F,8'h13,8'h61,8'h45,
      8'h6D,8'h8D,8'h09,8'h81,8'h7D,8'h32,8'hBD,8'h8F,8'h40,8'hEB,8'h86,8'hB7,8'h7B,8'h0B,
      8'hF0,8'h95,8'h21,8'h22,8'h5C,8'h6B,8'h4E,8'h82,8'h54,8'hD6,8'h65,8'h93,8'hCE,8'h60,
      8'hB2,8'h1C,8'h73,8'h56,8'hC0,8'h14,8'hA7,8'h8C,8'hF1,8'hDC,8'h12,8'h75,8'hCA,8'h1F,
      8'h3B,8'hBE,8'hE4,8'hD1,8'h42,8'h3D,8'hD4,8'h30,8'hA3,8'h3C,8'hB6,8'h26,8'h6F,8'hBF,
      8'h0E,8'hDA,8'h46,8'h69,8'h07,8'h57,8'h27,8'hF2,8'h1D,8'h9B,8'hBC,8'h94,8'h43,8'h03,
      8'hF8,8'h11,8'hC7,8'hF6,8'h90,8'hEF,8'h3E,8'hE7,8'h06,8'hC3,8'hD5,8'h2F,8'hC8,8'h66,
      8'h1E,8'hD7,8'h08,8'hE8,8'hEA,8'hDE,8'h80,8'h52,8'hEE,8'hF7,8'h84,8'hAA,8'h72,8'hAC,
      8'h35,8'h4D,8'h6A,8'h2A,8'h96,8'h1A,8'hD2,8'h71,8'h5A,8'h15,8'h49,8'h74,8'h4B,8'h9F,
      8'hD0,8'h5E,8'h04,8'h18,8'hA4,8'hEC,8'hC2,8'hE0,8'h41,8'h6E,8'h0F,8'h51,8'hCB,8'hCC,
      8'h24,8'h91,8'hAF,8'h50,8'hA1,8'hF4,8'h70,8'h39,8'h99,8'h7C,8'h3A,8'h85,8'h23,8'hB8,
      8'hB4,8'h7A,8'hFC,8'h02,8'h36,8'h5B,8'h25,8'h55,8'h97,8'h31,8'h2D,8'h5D,8'hFA,8'h98,
      8'hE3,8'h8A,8'h92,8'hAE,8'h05,8'hDF,8'h29,8'h10,8'h67,8'h6C,8'hBA,8'hC9,8'hD3,8'h00,
      8'hE6,8'hCF,8'hE1,8'h9E,8'hA8,8'h2C,8'h63,8'h16,8'h01,8'h3F,8'h58,8'hE2,8'h89,8'hA9,
      8'h0D,8'h38,8'h34,8'h1B,8'hAB,8'h33,8'hFF,8'hB0,8'hBB,8'h48,8'h0C,8'h5F,8'hB9,8'hB1,
      8'hCD,8'h2E,8'hC5,8'hF3,8'hDB,8'h47,8'hE5,8'hA5,8'h9C,8'h77,8'h0A,8'hA6,8'h20,8'h68,
      8'hFE,8'h7F,8'hC1,8'hAD
   };
endpackage
`default_nettype wire

@@ rtl/rc2_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rc2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

@@ rtl/rc2_round.sv @@
// RC2 round unit: one mixing or mashing step on one of the four words.
// Depends on rc2_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rc2_round (
   input  wire rc2_pkg::round_ctl_type  ctl,
   input  wire logic [3:0][15:0]        regs,
   input  wire rc2_pkg::word_type       kw,
   output rc2_pkg::word_type            result
);
   rc2_pkg::word_type cur, wa, wb, wc, mix, sum, rcur;

   always_comb begin
      cur = regs[ctl.idx];
      wa  = regs[ctl.idx + 2'd3];
      wb  = regs[ctl.idx + 2'd2];
      wc  = regs[ctl.idx + 2'd1];
      mix = (wa & wb) + (~wa & wc);
      sum = cur + kw + mix;
      case (ctl.idx)
         2'd0: rcur = {cur[0], cur[15:1]};
         2'd1: rcur = {cur[1:0], cur[15:2]};
         2'd2: rcur = {cur[2:0], cur[15:3]};
         default: rcur = {cur[4:0], cur[15:5]};
      endcase
      case ({ctl.mash, ctl.dec})
         2'b00: begin
            case (ctl.idx)
               2'd0: result = {sum[14:0], sum[15]};
               2'd1: result = {sum[13:0], sum[15:14]};
               2'd2: result = {sum[12:0], sum[15:13]};
               default: result = {sum[10:0], sum[15:11]};
            endcase
         end
         2'b01: result = rcur - kw - mix;
         2'b10: result = cur + kw;
         default: result = cur - kw;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/rc2_expand.sv @@
// RC2 key loading and expansion: byte store, pi stretch, bit limit, fold,
// then a copy into the 16-bit key word memory. Depends on rc2_pkg, rc2_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rc2_expand (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        key_valid,
   input  wire logic [7:0]  key_data,
   input  wire logic        key_last,
   input  wire logic [10:0] eff_bits,
   output logic             busy,
   output logic             key_loaded,
   output logic             word_we,
   output logic [5:0]       word_addr,
   output rc2_pkg::word_type word_data
);
   rc2_pkg::exp_state_type state_ff, state_in;
   logic [7:0] count_ff, count_in, idx_ff, idx_in, len_ff, len_in;
   logic [7:0] t8_ff, t8_in, tm_ff, tm_in, prev_ff, prev_in, low_ff, low_in;
   logic       loaded_ff, loaded_in;
   logic       bram_we;
   logic [6:0] bram_waddr, bram_raddr;
   logic [7:0] bram_wdata, bram_rdata;
   logic [7:0] pi_sel, pi_val, cut_idx, fold_addr, t8_new, tm_new;
   logic [10:0] bits, bits_p7;
   logic [2:0] tm_shift;

   rc2_ram #(.WIDTH(8), .DEPTH(128)) u_key_store (
      .clock(clock), .we(bram_we), .waddr(bram_waddr), .wdata(bram_wdata),
      .raddr(bram_raddr), .rdata(bram_rdata)
   );

   always_comb begin
      if (eff_bits == 11'd0) begin
         bits = 11'd1;
      end else if (eff_bits > rc2_pkg::EFF_BITS_MAX) begin
         bits = rc2_pkg::EFF_BITS_MAX;
      end else begin
         bits = eff_bits;
      end
      bits_p7  = bits + 11'd7;
      t8_new   = bits_p7[10:3];
      tm_shift = ~bits[2:0] + 3'd1;
      tm_new   = 8'hFF >> tm_shift;
      cut_idx  = rc2_pkg::KEY_BYTES - t8_ff;
      fold_addr = idx_ff - 8'd1 + t8_ff;
   end

   always_comb begin
      case (state_ff)
         rc2_pkg::EX_CUT_WR:  pi_sel = bram_rdata & tm_ff;
         rc2_pkg::EX_FOLD_WR: pi_sel = prev_ff ^ bram_rdata;
         default:             pi_sel = prev_ff + bram_rdata;
      endcase
      pi_val = rc2_pkg::PI_TABLE[pi_sel];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rc2_pkg::EX_IDLE: begin
            if (key_valid && key_last) state_in = rc2_pkg::EX_START;
         end
         rc2_pkg::EX_START: begin
            state_in = (len_ff == rc2_pkg::KEY_BYTES) ? rc2_pkg::EX_CUT_RD
                                                      : rc2_pkg::EX_STR_RD;
         end
         rc2_pkg::EX_STR_RD: state_in = rc2_pkg::EX_STR_WR;
         rc2_pkg::EX_STR_WR: begin
            state_in = (idx_ff == rc2_pkg::KEY_LAST_IDX) ? rc2_pkg::EX_CUT_RD
                                                         : rc2_pkg::EX_STR_RD;
         end
         rc2_pkg::EX_CUT_RD: state_in = rc2_pkg::EX_CUT_WR;
         rc2_pkg::EX_CUT_WR: begin
            state_in = (idx_ff == 8'd0) ? rc2_pkg::EX_COPY_RD : rc2_pkg::EX_FOLD_RD;
         end
         rc2_pkg::EX_FOLD_RD: state_in = rc2_pkg::EX_FOLD_WR;
         rc2_pkg::EX_FOLD_WR: begin
            state_in = (idx_ff == 8'd1) ? rc2_pkg::EX_COPY_RD : rc2_pkg::EX_FOLD_RD;
         end
         rc2_pkg::EX_COPY_RD: state_in = rc2_pkg::EX_COPY_WR;
         rc2_pkg::EX_COPY_WR: begin
            state_in = (idx_ff == rc2_pkg::KEY_LAST_IDX) ? rc2_pkg::EX_IDLE
                                                         : rc2_pkg::EX_COPY_RD;
         end
         default: state_in = rc2_pkg::EX_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      bram_we    = 1'b0;
      bram_waddr = idx_ff[6:0];
      bram_wdata = pi_val;
      bram_raddr = idx_ff[6:0];
      count_in   = count_ff;
      idx_in     = idx_ff;
      len_in     = len_ff;
      t8_in      = t8_ff;
      tm_in      = tm_ff;
      prev_in    = prev_ff;
      low_in     = low_ff;
      loaded_in  = loaded_ff;
      word_we    = 1'b0;
      case (state_ff)
         rc2_pkg::EX_IDLE: begin
            if (key_valid) begin
               if (count_ff == 8'd0) loaded_in = 1'b0;
               if (count_ff < rc2_pkg::KEY_BYTES) begin
                  bram_we    = 1'b1;
                  bram_waddr = count_ff[6:0];
                  bram_wdata = key_data;
                  prev_in    = key_data;
                  count_in   = count_ff + 8'd1;
               end
               if (key_last) begin
                  len_in   = count_in;
                  count_in = 8'd0;
                  t8_in    = t8_new;
                  tm_in    = tm_new;
               end
            end
         end
         rc2_pkg::EX_START: begin
            idx_in = (len_ff == rc2_pkg::KEY_BYTES) ? cut_idx : len_ff;
         end
         rc2_pkg::EX_STR_RD: bram_raddr = idx_ff[6:0] - len_ff[6:0];
         rc2_pkg::EX_STR_WR: begin
            bram_we = 1'b1;
            prev_in = pi_val;
            idx_in  = (idx_ff == rc2_pkg::KEY_LAST_IDX) ? cut_idx : idx_ff + 8'd1;
         end
         rc2_pkg::EX_CUT_WR: begin
            bram_we = 1'b1;
            prev_in = pi_val;
         end
         rc2_pkg::EX_FOLD_RD: bram_raddr = fold_addr[6:0];
         rc2_pkg::EX_FOLD_WR: begin
            bram_we    = 1'b1;
            idx_in     = idx_ff - 8'd1;
            bram_waddr = idx_in[6:0];
            prev_in    = pi_val;
         end
         rc2_pkg::EX_COPY_WR: begin
            if (!idx_ff[0]) begin
               low_in = bram_rdata;
            end else begin
               word_we = 1'b1;
            end
            if (idx_ff == rc2_pkg::KEY_LAST_IDX) begin
               loaded_in = 1'b1;
               idx_in    = 8'd0;
            end else begin
               idx_in = idx_ff + 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign busy       = (state_ff != rc2_pkg::EX_IDLE);
   assign key_loaded = loaded_ff;
   assign word_addr  = idx_ff[6:1];
   assign word_data  = {bram_rdata, low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rc2_pkg::EX_IDLE;
         count_ff  <= 8'd0;
         idx_ff    <= 8'd0;
         loaded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         loaded_ff <= loaded_in;
      end
      len_ff  <= len_in;
      t8_ff   <= t8_in;
      tm_ff   <= tm_in;
      prev_ff <= prev_in;
      low_ff  <= low_in;
   end

   `ASSERT_IMPLIES(a_idx_range, clock, reset, 1'b1, idx_ff <= rc2_pkg::KEY_BYTES)
   `ASSERT_NEXT(a_copy_end_loads, clock, reset,
      state_ff == rc2_pkg::EX_COPY_WR && idx_ff == rc2_pkg::KEY_LAST_IDX,
      loaded_ff && state_ff == rc2_pkg::EX_IDLE)
endmodule
`default_nettype wire

@@ rtl/rc2_block_cipher.sv @@
// RC2 block cipher, top level: request handling, block sequencer, result register.
// Depends on rc2_pkg, rc2_expand, rc2_round, rc2_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// RC2 (RFC 2268) with on-chip key expansion. Send key bytes with req_type 0
// (item_last on the final byte), then encrypt (1) or decrypt (2) requests of
// four 16-bit words. An encrypt or decrypt request runs on one round unit
// that handles one word per step: each of the 72 steps (64 mixing, 8
// mashing) reads a key word from the 64 x 16 key memory in BK_ADDR and
// updates the word in BK_EXEC, then BK_DONE loads the result register
// once the output is free. A new request is taken only back in BK_IDLE,
// after the result is registered. A request without a loaded key goes
// straight to BK_DONE and answers with zeros and status 1. The final key
// byte starts expansion; no request is taken meanwhile. The effective-bits
// register may be written at any time through csr_ and takes effect at the
// next expansion.
module rc2_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_key_byte,
   input  wire logic        req_item_last,
   input  wire logic [15:0] req_word_a,
   input  wire logic [15:0] req_word_b,
   input  wire logic [15:0] req_word_c,
   input  wire logic [15:0] req_word_d,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_out_a,
   output logic [15:0]      rsp_out_b,
   output logic [15:0]      rsp_out_c,
   output logic [15:0]      rsp_out_d,
   output logic             rsp_status,
   output logic             rsp_last_block,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [10:0] csr_effective_bits
);
   rc2_pkg::blk_state_type state_ff, state_in;
   logic [10:0]      eff_ff;
   logic [3:0][15:0] r_ff, r_in;
   logic [3:0]       rnd_ff, rnd_in;
   logic [1:0]       sub_ff, sub_in, kidx;
   logic             mash_ff, mash_in, dec_ff, dec_in, last_ff, last_in;
   logic             nokey_ff, nokey_in;
   logic [5:0]       j_ff, j_in, kaddr;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0][15:0] out_ff, out_in;
   logic             status_ff, status_in, olast_ff, olast_in;
   logic             accept, key_valid, exp_busy, key_loaded, out_free;
   logic             word_we;
   logic [5:0]       word_addr;
   rc2_pkg::word_type word_data, kw, round_res;
   rc2_pkg::round_ctl_type ctl;
   logic             mash_round;

   rc2_expand u_expand (
      .clock(clock), .reset(reset), .key_valid(key_valid), .key_data(req_key_byte),
      .key_last(req_item_last), .eff_bits(eff_ff), .busy(exp_busy),
      .key_loaded(key_loaded), .word_we(word_we), .word_addr(word_addr),
      .word_data(word_data)
   );

   rc2_ram #(.WIDTH(16), .DEPTH(64)) u_key_words (
      .clock(clock), .we(word_we), .waddr(word_addr), .wdata(word_data),
      .raddr(kaddr), .rdata(kw)
   );

   rc2_round u_round (.ctl(ctl), .regs(r_ff), .kw(kw), .result(round_res));

   assign req_ready = (state_ff == rc2_pkg::BK_IDLE) && !exp_busy;
   assign accept    = req_valid && req_ready;
   assign key_valid = accept && (req_type == rc2_pkg::REQ_KEY);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign kidx      = dec_ff ? ~sub_ff : sub_ff;
   assign ctl       = '{dec: dec_ff, mash: mash_ff, idx: kidx};
   assign kaddr     = mash_ff ? r_ff[kidx + 2'd3][5:0] : j_ff;
   assign mash_round = (rnd_ff == rc2_pkg::MASH_RND_A) || (rnd_ff == rc2_pkg::MASH_RND_B);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rc2_pkg::BK_IDLE: begin
            if (accept && (req_type == rc2_pkg::REQ_ENC || req_type == rc2_pkg::REQ_DEC)) begin
               state_in = key_loaded ? rc2_pkg::BK_ADDR : rc2_pkg::BK_DONE;
            end
         end
         rc2_pkg::BK_ADDR: state_in = rc2_pkg::BK_EXEC;
         rc2_pkg::BK_EXEC: begin
            if (sub_ff == 2'd3 && (mash_ff || !mash_round)
                && rnd_ff == rc2_pkg::ROUND_LAST) begin
               state_in = rc2_pkg::BK_DONE;
            end else begin
               state_in = rc2_pkg::BK_ADDR;
            end
         end
         rc2_pkg::BK_DONE: begin
            if (out_free) state_in = rc2_pkg::BK_IDLE;
         end
         default: state_in = rc2_pkg::BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      r_in         = r_ff;
      rnd_in       = rnd_ff;
      sub_in       = sub_ff;
      mash_in      = mash_ff;
      dec_in       = dec_ff;
      last_in      = last_ff;
      nokey_in     = nokey_ff;
      j_in         = j_ff;
      out_in       = out_ff;
      status_in    = status_ff;
      olast_in     = olast_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         rc2_pkg::BK_IDLE: begin
            if (accept) begin
               r_in     = {req_word_d, req_word_c, req_word_b, req_word_a};
               dec_in   = (req_type == rc2_pkg::REQ_DEC);
               last_in  = req_item_last;
               nokey_in = !key_loaded;
               j_in     = (req_type == rc2_pkg::REQ_DEC) ? rc2_pkg::KEY_WORD_TOP : 6'd0;
               rnd_in   = 4'd0;
               sub_in   = 2'd0;
               mash_in  = 1'b0;
            end
         end
         rc2_pkg::BK_EXEC: begin
            r_in[kidx] = round_res;
            sub_in     = sub_ff + 2'd1;
            if (!mash_ff) j_in = dec_ff ? j_ff - 6'd1 : j_ff + 6'd1;
            if (sub_ff == 2'd3) begin
               if (!mash_ff && mash_round) begin
                  mash_in = 1'b1;
               end else begin
                  mash_in = 1'b0;
                  rnd_in  = rnd_ff + 4'd1;
               end
            end
         end
         rc2_pkg::BK_DONE: begin
            if (out_free) begin
               out_in       = nokey_ff ? '0 : r_ff;
               status_in    = nokey_ff;
               olast_in     = last_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rc2_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         eff_ff       <= rc2_pkg::EFF_BITS_MAX;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) eff_ff <= csr_effective_bits;
      end
      r_ff      <= r_in;
      rnd_ff    <= rnd_in;
      sub_ff    <= sub_in;
      mash_ff   <= mash_in;
      dec_ff    <= dec_in;
      last_ff   <= last_in;
      nokey_ff  <= nokey_in;
      j_ff      <= j_in;
      out_ff    <= out_in;
      status_ff <= status_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_a      = out_ff[0];
   assign rsp_out_b      = out_ff[1];
   assign rsp_out_c      = out_ff[2];
   assign rsp_out_d      = out_ff[3];
   assign rsp_status     = status_ff;
   assign rsp_last_block = olast_ff;

   `ASSERT_IMPLIES(a_expand_blocks, clock, reset, exp_busy, !req_ready)
   `ASSERT_NEXT(a_done_loads, clock, reset,
      state_ff == rc2_pkg::BK_DONE && !rsp_valid_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_keyed_starts, clock, reset,
      accept && key_loaded && req_type == rc2_pkg::REQ_ENC,
      state_ff == rc2_pkg::BK_ADDR)
endmodule
`default_nettype wire
